### sv/video_register_and_vram_port_assert.svh
// Assertion macros for the video register and VRAM port.
`ifndef VIDEO_REGISTER_AND_VRAM_PORT_ASSERT_SVH
`define VIDEO_REGISTER_AND_VRAM_PORT_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define VRP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vrp assertion failed");
// next-cycle implication
`define VRP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vrp assertion failed");
`else
`define VRP_ASSERT_NOW(lbl, ante, cons)
`define VRP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### sv/vrp_pkg.sv
// Shared types, codes and helpers for the video register and VRAM port.
`default_nettype none
package vrp_pkg;
  localparam int VRP_NAME_RAM_BYTES = 4096;
  localparam int VRP_SPRITE_MEM_BYTES = 256;
  localparam int SPR_AW = $clog2(VRP_SPRITE_MEM_BYTES);

  typedef enum logic [2:0] {
    KIND_READ, KIND_WRITE, KIND_INC_X, KIND_INC_Y,
    KIND_COPY_X, KIND_COPY_Y, KIND_VBLANK, KIND_FRAME_CLR
  } kind_t;

  // CPU register numbers
  localparam logic [2:0] REG_CTRL     = 3'd0;
  localparam logic [2:0] REG_MASK     = 3'd1;
  localparam logic [2:0] REG_STATUS   = 3'd2;
  localparam logic [2:0] REG_OAM_ADDR = 3'd3;
  localparam logic [2:0] REG_OAM_DATA = 3'd4;
  localparam logic [2:0] REG_SCROLL   = 3'd5;
  localparam logic [2:0] REG_ADDR     = 3'd6;
  localparam logic [2:0] REG_DATA     = 3'd7;

  // configuration register indexes
  localparam logic CFG_MIRRORING   = 1'b0;
  localparam logic CFG_PATTERN_RAM = 1'b1;

  localparam logic [1:0] MIRROR_VERT = 2'd1;
  localparam logic [1:0] MIRROR_FOUR = 2'd2;

  typedef struct packed {
    kind_t       kind;
    logic [2:0]  reg_index;
    logic [7:0]  data;
    logic [7:0]  pattern_byte;
  } item_t;

  // where the returned byte comes from
  typedef enum logic [2:0] {RD_NONE, RD_LATCH, RD_FIXED, RD_SPRITE, RD_BUFFER} rd_sel_t;
  // what reloads the read buffer
  typedef enum logic [1:0] {BUF_KEEP, BUF_PATTERN, BUF_NAME} buf_sel_t;

  // nametable offset to RAM index by mirroring mode
  function automatic logic [11:0] nt_index(input logic [1:0] mir, input logic [11:0] off);
    logic [11:0] idx;
    case (mir)
      MIRROR_VERT: idx = {1'b0, off[10], off[9:0]};
      MIRROR_FOUR: idx = off;
      default:     idx = {1'b0, off[11], off[9:0]};
    endcase
    return idx;
  endfunction
endpackage
`default_nettype wire

### sv/vrp_if.sv
// Valid/ready channel interfaces for items and results.
`default_nettype none
interface vrp_in_if import vrp_pkg::*;;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [2:0]  reg_index;
  logic [7:0]  data;
  logic [7:0]  pattern_byte;
  modport source (output valid, kind, reg_index, data, pattern_byte, input ready);
  modport sink (input valid, kind, reg_index, data, pattern_byte, output ready);
endinterface

interface vrp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic        nmi;
  logic [14:0] vram_addr;
  logic [2:0]  fine_x;
  logic        pattern_write;
  logic [12:0] pattern_addr;
  logic [7:0]  pattern_data;
  modport source (output valid, read_data, nmi, vram_addr, fine_x, pattern_write,
                  pattern_addr, pattern_data, input ready);
  modport sink (input valid, read_data, nmi, vram_addr, fine_x, pattern_write,
                pattern_addr, pattern_data, output ready);
endinterface
`default_nettype wire

### sv/vrp_queue.sv
// Front end: accepts items, tags the kind and holds them in a two-entry queue.
`default_nettype none
module vrp_queue import vrp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  vrp_in_if.sink    in_ch,
  input  wire logic hold,
  output item_t     q_item,
  output logic      q_valid,
  input  wire logic q_pop
);
  item_t       ent_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;
  logic        push;

  assign in_ch.ready = (cnt_r != 2'd2) && !hold;
  assign push = in_ch.valid && in_ch.ready;
  assign q_valid = (cnt_r != 2'd0);
  assign q_item = ent_r[rp_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= '{kind: kind_t'(in_ch.kind), reg_index: in_ch.reg_index,
                       data: in_ch.data, pattern_byte: in_ch.pattern_byte};
    end
  end
endmodule
`default_nettype wire

### sv/vrp_exec.sv
// Back end: register state, memories and result stage.
`default_nettype none
module vrp_exec import vrp_pkg::*; #(
  parameter int NAME_RAM_BYTES = VRP_NAME_RAM_BYTES
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [1:0]  cfg_data,
  input  wire item_t       q_item,
  input  wire logic        q_valid,
  output logic             q_pop,
  output logic             clearing,
  vrp_out_if.source        out_ch
);
  localparam int NAW = $clog2(NAME_RAM_BYTES);

  // architectural state
  logic [1:0]  mir_r;
  logic        pram_r;
  logic [7:0]  ctrl_r, mask_r, spr_addr_r;
  logic [2:0]  status_r, fx_r;
  logic [14:0] v_r, t_r;
  logic        w_r, vbl_r, nmi_sent_r;
  logic [7:0]  pal_r [32];
  logic        spr_vld_r [VRP_SPRITE_MEM_BYTES];
  logic [7:0]  spr_mem [VRP_SPRITE_MEM_BYTES];
  logic [7:0]  name_mem [NAME_RAM_BYTES];
  logic        clr_r;
  logic [NAW-1:0] clr_cnt_r;

  // result stage
  logic        wv_r;
  rd_sel_t     w_sel_r;
  buf_sel_t    w_buf_r;
  logic [7:0]  w_fixed_r, w_pbyte_r, w_pd_r;
  logic        w_nmi_r, w_pw_r, w_sprv_r;
  logic [14:0] w_v_r;
  logic [2:0]  w_fx_r;
  logic [12:0] w_pa_r;
  logic [7:0]  spr_rdata_r, name_rdata_r, rbuf_r, latch_r;

  // next state
  logic [7:0]  ctrl_nxt, mask_nxt, spr_addr_nxt;
  logic [2:0]  status_nxt, fx_nxt;
  logic [14:0] v_nxt, t_nxt, v_step, v_tmp;
  logic        w_nxt, vbl_nxt, nmi_sent_nxt;
  rd_sel_t     sel_nxt;
  buf_sel_t    buf_nxt;
  logic [7:0]  fixed_nxt, pd_nxt;
  logic        nmi_nxt, pw_nxt;
  logic [12:0] pa_nxt;
  logic [13:0] a;
  logic [NAW-1:0] name_idx;
  logic        name_re, name_we, spr_re, spr_we, pal_we, pal_dual;
  logic [4:0]  y;
  logic        go, render;
  logic [7:0]  rd_val;

  assign clearing = clr_r;
  assign go = q_valid && !clr_r && (!wv_r || out_ch.ready);
  assign q_pop = go;
  assign a = v_r[13:0];
  assign name_idx = NAW'(nt_index(mir_r, a[11:0]));
  assign v_step = v_r + (ctrl_r[2] ? 15'd32 : 15'd1);
  assign render = !vbl_r && (mask_r[3] || mask_r[4]);

  // decode and execute one item
  always_comb begin
    ctrl_nxt = ctrl_r; mask_nxt = mask_r; spr_addr_nxt = spr_addr_r;
    status_nxt = status_r; fx_nxt = fx_r; v_nxt = v_r; t_nxt = t_r;
    w_nxt = w_r; vbl_nxt = vbl_r; nmi_sent_nxt = nmi_sent_r;
    sel_nxt = RD_NONE; buf_nxt = BUF_KEEP; fixed_nxt = 8'd0;
    nmi_nxt = 1'b0; pw_nxt = 1'b0; pa_nxt = 13'd0; pd_nxt = 8'd0;
    name_re = 1'b0; name_we = 1'b0; spr_re = 1'b0; spr_we = 1'b0;
    pal_we = 1'b0; pal_dual = 1'b0; v_tmp = v_r; y = v_r[9:5];
    case (q_item.kind)
      KIND_READ: begin
        case (q_item.reg_index)
          REG_STATUS: begin
            sel_nxt = RD_FIXED;
            fixed_nxt = {status_r, 5'd0};
            status_nxt = {1'b0, status_r[1:0]};
            w_nxt = 1'b0;
          end
          REG_OAM_DATA: begin
            sel_nxt = RD_SPRITE;
            spr_re = 1'b1;
          end
          REG_DATA: begin
            v_nxt = v_step;
            if (a < 14'h2000) begin
              sel_nxt = RD_BUFFER;
              buf_nxt = BUF_PATTERN;
              pa_nxt = a[12:0];
            end else if (a < 14'h3F00) begin
              sel_nxt = RD_BUFFER;
              buf_nxt = BUF_NAME;
              name_re = 1'b1;
            end else begin
              sel_nxt = RD_FIXED;
              fixed_nxt = pal_r[a[4:0]];
              buf_nxt = BUF_NAME;
              name_re = 1'b1;
            end
          end
          default: sel_nxt = RD_LATCH;
        endcase
      end
      KIND_WRITE: begin
        case (q_item.reg_index)
          REG_CTRL: begin
            ctrl_nxt = q_item.data;
            t_nxt[11:10] = q_item.data[1:0];
            if (vbl_r && !ctrl_r[7] && q_item.data[7] && !nmi_sent_r) begin
              nmi_nxt = 1'b1;
              nmi_sent_nxt = 1'b1;
            end
          end
          REG_MASK: mask_nxt = q_item.data;
          REG_OAM_ADDR: spr_addr_nxt = q_item.data;
          REG_OAM_DATA: begin
            spr_we = 1'b1;
            spr_addr_nxt = spr_addr_r + 8'd1;
          end
          REG_SCROLL: begin
            if (!w_r) begin
              t_nxt[4:0] = q_item.data[7:3];
              fx_nxt = q_item.data[2:0];
              w_nxt = 1'b1;
            end else begin
              t_nxt[9:5] = q_item.data[7:3];
              t_nxt[14:12] = q_item.data[2:0];
              w_nxt = 1'b0;
            end
          end
          REG_ADDR: begin
            if (!w_r) begin
              t_nxt[14:8] = {1'b0, q_item.data[5:0]};
              w_nxt = 1'b1;
            end else begin
              t_nxt = {t_r[14:8], q_item.data};
              v_nxt = {t_r[14:8], q_item.data};
              w_nxt = 1'b0;
            end
          end
          REG_DATA: begin
            v_nxt = v_step;
            if (a < 14'h2000) begin
              pa_nxt = a[12:0];
              if (pram_r) begin
                pw_nxt = 1'b1;
                pd_nxt = q_item.data;
              end
            end else if (a < 14'h3F00) begin
              name_we = 1'b1;
            end else begin
              pal_we = 1'b1;
              pal_dual = (a[1:0] == 2'd0);
            end
          end
          default: ;
        endcase
      end
      KIND_VBLANK: begin
        vbl_nxt = 1'b1;
        status_nxt = status_r | 3'b100;
        nmi_nxt = ctrl_r[7];
        nmi_sent_nxt = ctrl_r[7];
      end
      KIND_FRAME_CLR: begin
        vbl_nxt = 1'b0;
        status_nxt = 3'd0;
      end
      KIND_INC_X: begin
        if (render) begin
          if (v_r[4:0] == 5'd31) v_nxt = {v_r[14:11], ~v_r[10], v_r[9:5], 5'd0};
          else v_nxt = v_r + 15'd1;
        end
      end
      KIND_INC_Y: begin
        if (render) begin
          if (v_r[14:12] != 3'd7) begin
            v_nxt = v_r + 15'h1000;
          end else begin
            v_tmp = {3'd0, v_r[11:0]};
            if (v_r[9:5] == 5'd29) begin
              y = 5'd0;
              v_tmp[11] = ~v_tmp[11];
            end else if (v_r[9:5] == 5'd31) begin
              y = 5'd0;
            end else begin
              y = v_r[9:5] + 5'd1;
            end
            v_nxt = {v_tmp[14:10], y, v_tmp[4:0]};
          end
        end
      end
      KIND_COPY_X: begin
        if (render) v_nxt = (v_r & ~15'h041F) | (t_r & 15'h041F);
      end
      KIND_COPY_Y: begin
        if (render) v_nxt = (v_r & ~15'h7BE0) | (t_r & 15'h7BE0);
      end
      default: ;
    endcase
  end

  // control and scroll registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mir_r <= 2'd0; pram_r <= 1'b0;
      ctrl_r <= 8'd0; mask_r <= 8'd0; spr_addr_r <= 8'd0;
      status_r <= 3'd0; fx_r <= 3'd0; v_r <= 15'd0; t_r <= 15'd0;
      w_r <= 1'b0; vbl_r <= 1'b0; nmi_sent_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_MIRRORING) mir_r <= cfg_data;
        else pram_r <= cfg_data[0];
      end
      if (go) begin
        ctrl_r <= ctrl_nxt; mask_r <= mask_nxt; spr_addr_r <= spr_addr_nxt;
        status_r <= status_nxt; fx_r <= fx_nxt; v_r <= v_nxt; t_r <= t_nxt;
        w_r <= w_nxt; vbl_r <= vbl_nxt; nmi_sent_r <= nmi_sent_nxt;
      end
    end
  end

  // palette, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 32; i++) pal_r[i] <= 8'd0;
    end else if (go && pal_we) begin
      if (pal_dual) begin
        pal_r[{1'b0, a[3:0]}] <= q_item.data;
        pal_r[{1'b1, a[3:0]}] <= q_item.data;
      end else begin
        pal_r[a[4:0]] <= q_item.data;
      end
    end
  end

  // sprite memory valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < VRP_SPRITE_MEM_BYTES; i++) spr_vld_r[i] <= 1'b0;
    end else if (go && spr_we) begin
      spr_vld_r[spr_addr_r] <= 1'b1;
    end
  end

  // sprite memory
  always_ff @(posedge clk) begin
    if (go && spr_we) spr_mem[spr_addr_r] <= q_item.data;
    if (go && spr_re) spr_rdata_r <= spr_mem[spr_addr_r];
  end

  // nametable clear sweep after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= 1'b1;
      clr_cnt_r <= '0;
    end else if (clr_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == NAW'(NAME_RAM_BYTES - 1)) clr_r <= 1'b0;
    end
  end

  // nametable memory
  always_ff @(posedge clk) begin
    if (clr_r) name_mem[clr_cnt_r] <= 8'd0;
    else if (go && name_we) name_mem[name_idx] <= q_item.data;
    if (go && name_re) name_rdata_r <= name_mem[name_idx];
  end

  // result byte
  always_comb begin
    case (w_sel_r)
      RD_LATCH:  rd_val = latch_r;
      RD_FIXED:  rd_val = w_fixed_r;
      RD_SPRITE: rd_val = w_sprv_r ? spr_rdata_r : 8'd0;
      RD_BUFFER: rd_val = rbuf_r;
      default:   rd_val = 8'd0;
    endcase
  end

  // result stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wv_r <= 1'b0;
      rbuf_r <= 8'd0;
      latch_r <= 8'd0;
    end else begin
      if (go) wv_r <= 1'b1;
      else if (out_ch.ready) wv_r <= 1'b0;
      if (wv_r && out_ch.ready) begin
        if (w_sel_r != RD_NONE) latch_r <= rd_val;
        case (w_buf_r)
          BUF_PATTERN: rbuf_r <= w_pbyte_r;
          BUF_NAME:    rbuf_r <= name_rdata_r;
          default:     ;
        endcase
      end
    end
  end

  // result stage payload
  always_ff @(posedge clk) begin
    if (go) begin
      w_sel_r <= sel_nxt; w_buf_r <= buf_nxt; w_fixed_r <= fixed_nxt;
      w_pbyte_r <= q_item.pattern_byte; w_pd_r <= pd_nxt; w_nmi_r <= nmi_nxt;
      w_pw_r <= pw_nxt; w_sprv_r <= spr_vld_r[spr_addr_r];
      w_v_r <= v_nxt; w_fx_r <= fx_nxt; w_pa_r <= pa_nxt;
    end
  end

  assign out_ch.valid = wv_r;
  assign out_ch.read_data = rd_val;
  assign out_ch.nmi = w_nmi_r;
  assign out_ch.vram_addr = w_v_r;
  assign out_ch.fine_x = w_fx_r;
  assign out_ch.pattern_write = w_pw_r;
  assign out_ch.pattern_addr = w_pa_r;
  assign out_ch.pattern_data = w_pd_r;
endmodule
`default_nettype wire

### sv/video_register_and_vram_port.sv
// Top level of the video register and VRAM port.
// Use: items (CPU register reads/writes and render events) enter on in_ch,
// one result per item leaves on out_ch; both are valid/ready channels.
// Configuration (mirroring, pattern RAM enable) is written on cfg_we; the user
// must write it only while idle; the block itself does not enforce this.
// Throughput: one item per cycle while the receiver takes results. An accepted
// item is stored in the front queue, executed from there, and its result is
// registered in the output stage. The nametable and sprite memories are read
// registered, and their data joins the result in the output stage.
// Reset: control registers, the palette and the sprite valid bits clear at
// once; the nametable RAM is then swept to zero, one byte a cycle over its
// NAME_RAM_BYTES bytes (4096 by default); in_ch.ready is low during the sweep.
// When the receiver stalls, the result holds, execution pauses and the
// two-entry front queue keeps taking items until it is full.
`default_nettype none
module video_register_and_vram_port import vrp_pkg::*; #(
  parameter int NAME_RAM_BYTES = VRP_NAME_RAM_BYTES
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [1:0] cfg_data,
  vrp_in_if.sink          in_ch,
  vrp_out_if.source       out_ch
);
  `include "video_register_and_vram_port_assert.svh"

  item_t q_item;
  logic  q_valid, q_pop, clearing;

  vrp_queue u_queue (
    .clk, .rst_n, .in_ch, .hold(clearing), .q_item, .q_valid, .q_pop
  );

  vrp_exec #(.NAME_RAM_BYTES(NAME_RAM_BYTES)) u_exec (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .q_item, .q_valid, .q_pop, .clearing, .out_ch
  );

  `VRP_ASSERT_NOW(a_no_accept_in_clear, clearing, !in_ch.ready)
  `VRP_ASSERT_NOW(a_nmi_not_with_pwrite, out_ch.valid, !(out_ch.nmi && out_ch.pattern_write))
  `VRP_ASSERT_NOW(a_pdata_zero, out_ch.valid && !out_ch.pattern_write, out_ch.pattern_data == 8'd0)
  `VRP_ASSERT_NEXT(a_pop_makes_result, q_pop, out_ch.valid)
endmodule
`default_nettype wire

### test/video_register_and_vram_port_test.sv
// Testbench for the video register and VRAM port: scoreboard against a behavioral predictor.
`timescale 1ns / 1ps
`default_nettype none
module video_register_and_vram_port_test;
  import vrp_pkg::*;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        nmi;
    logic [14:0] vram_addr;
    logic [2:0]  fine_x;
    logic        pattern_write;
    logic [12:0] pattern_addr;
    logic [7:0]  pattern_data;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_MIRRORING;
  logic [1:0] cfg_data = 2'd0;

  vrp_in_if in_ch ();
  vrp_out_if out_ch ();

  video_register_and_vram_port dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always #4 clk = ~clk;

  // predictor state
  logic [1:0]  mir_mode;
  logic        pat_ram_en;
  logic [7:0]  ctrl_r, mask_r, latch_r, rbuf_r, oam_addr_r;
  logic [2:0]  stat_r, fx_r;
  logic [14:0] v_r, t_r;
  logic        toggle_r, vblank_r, nmi_done_r;
  logic [7:0]  oam_mem [256];
  logic [7:0]  nt_mem [4096];
  logic [7:0]  pal_mem [32];

  item_t   pending_items [$];
  result_t expected_results [$];
  int      errors = 0;
  bit      stim_done = 1'b0;

  function automatic int unsigned nt_slot(logic [11:0] off);
    case (mir_mode)
      2'd1: return {off[10], off[9:0]};
      2'd2: return off;
      default: return {off[11], off[9:0]};
    endcase
  endfunction

  function automatic logic raise_nmi();
    if (ctrl_r[7] && vblank_r && !nmi_done_r) begin
      nmi_done_r = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void bump_v();
    v_r = v_r + (ctrl_r[2] ? 15'd32 : 15'd1);
  endfunction

  // compute the result of one item and update predictor state
  function automatic result_t predict_result(item_t it);
    result_t r;
    logic [13:0] a;
    logic [7:0]  val;
    logic [14:0] v;
    logic [4:0]  y;
    r = '0;
    case (it.kind)
      KIND_READ: begin
        if (it.reg_index == REG_STATUS) begin
          latch_r = {stat_r, 5'd0};
          stat_r[2] = 1'b0;
          toggle_r = 1'b0;
        end else if (it.reg_index == REG_OAM_DATA) begin
          latch_r = oam_mem[oam_addr_r];
        end else if (it.reg_index == REG_DATA) begin
          a = v_r[13:0];
          if (a < 14'h2000) begin
            val = rbuf_r; rbuf_r = it.pattern_byte; r.pattern_addr = a[12:0];
          end else if (a < 14'h3F00) begin
            if (a >= 14'h3000) a = a - 14'h1000;
            val = rbuf_r; rbuf_r = nt_mem[nt_slot(a[11:0])];
          end else begin
            rbuf_r = nt_mem[nt_slot(a[11:0])];
            val = pal_mem[a[4:0]];
          end
          bump_v();
          latch_r = val;
        end
        r.read_data = latch_r;
      end
      KIND_WRITE: begin
        case (it.reg_index)
          REG_CTRL: begin
            val = ctrl_r;
            ctrl_r = it.data;
            t_r[11:10] = it.data[1:0];
            if (vblank_r && !val[7] && it.data[7]) r.nmi = raise_nmi();
          end
          REG_MASK: mask_r = it.data;
          REG_OAM_ADDR: oam_addr_r = it.data;
          REG_OAM_DATA: begin
            oam_mem[oam_addr_r] = it.data;
            oam_addr_r = oam_addr_r + 8'd1;
          end
          REG_SCROLL: begin
            if (!toggle_r) begin
              t_r[4:0] = it.data[7:3]; fx_r = it.data[2:0];
            end else begin
              t_r[9:5] = it.data[7:3]; t_r[14:12] = it.data[2:0];
            end
            toggle_r = ~toggle_r;
          end
          REG_ADDR: begin
            if (!toggle_r) begin
              t_r[14:8] = {1'b0, it.data[5:0]};
            end else begin
              t_r[7:0] = it.data; v_r = t_r;
            end
            toggle_r = ~toggle_r;
          end
          REG_DATA: begin
            a = v_r[13:0];
            if (a < 14'h2000) begin
              r.pattern_addr = a[12:0];
              if (pat_ram_en) begin
                r.pattern_write = 1'b1; r.pattern_data = it.data;
              end
            end else if (a < 14'h3F00) begin
              if (a >= 14'h3000) a = a - 14'h1000;
              nt_mem[nt_slot(a[11:0])] = it.data;
            end else if (a[1:0] != 2'd0) begin
              pal_mem[a[4:0]] = it.data;
            end else begin
              pal_mem[{1'b0, a[3:0]}] = it.data;
              pal_mem[{1'b1, a[3:0]}] = it.data;
            end
            bump_v();
          end
          default: ;
        endcase
      end
      KIND_VBLANK: begin
        vblank_r = 1'b1; nmi_done_r = 1'b0; stat_r[2] = 1'b1;
        r.nmi = raise_nmi();
      end
      KIND_FRAME_CLR: begin
        vblank_r = 1'b0; stat_r = 3'd0;
      end
      default: begin
        if (!vblank_r && mask_r[4:3] != 2'b00) begin
          v = v_r;
          case (it.kind)
            KIND_INC_X: begin
              if (v[4:0] == 5'd31) begin
                v[4:0] = 5'd0; v[10] = ~v[10];
              end else v = v + 15'd1;
            end
            KIND_INC_Y: begin
              if (v[14:12] != 3'd7) begin
                v[14:12] = v[14:12] + 3'd1;
              end else begin
                y = v[9:5];
                v[14:12] = 3'd0;
                if (y == 5'd29) begin
                  y = 5'd0; v[11] = ~v[11];
                end else if (y == 5'd31) y = 5'd0;
                else y = y + 5'd1;
                v[9:5] = y;
              end
            end
            KIND_COPY_X: begin
              v[10] = t_r[10]; v[4:0] = t_r[4:0];
            end
            default: begin
              v[14:11] = t_r[14:11]; v[9:5] = t_r[9:5];
            end
          endcase
          v_r = v;
        end
      end
    endcase
    r.vram_addr = v_r;
    r.fine_x = fx_r;
    return r;
  endfunction

  function automatic item_t mk(kind_t k, logic [2:0] ri, logic [7:0] d, logic [7:0] pb);
    item_t it;
    it.kind = k; it.reg_index = ri; it.data = d; it.pattern_byte = pb;
    return it;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // driver
  int in_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_ch.ready) begin
      // hold the item
    end else begin
      if (in_ch.valid) begin
        expected_results.push_back(predict_result(pending_items.pop_front()));
        in_gap = gap_len();
      end
      if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_ch.valid <= 1'b1;
        {in_ch.kind, in_ch.reg_index, in_ch.data, in_ch.pattern_byte} <= pending_items[0];
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor
  int out_gap = 0;
  always @(posedge clk) begin
    result_t got, want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.read_data, out_ch.nmi, out_ch.vram_addr, out_ch.fine_x,
               out_ch.pattern_write, out_ch.pattern_addr, out_ch.pattern_data};
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch, expected rd=%h nmi=%b v=%h fx=%h pw=%b pa=%h pd=%h",
                     $time, want.read_data, want.nmi, want.vram_addr, want.fine_x,
                     want.pattern_write, want.pattern_addr, want.pattern_data);
            $display("%0t:           actual rd=%h nmi=%b v=%h fx=%h pw=%b pa=%h pd=%h",
                     $time, got.read_data, got.nmi, got.vram_addr, got.fine_x,
                     got.pattern_write, got.pattern_addr, got.pattern_data);
            errors++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_gap = gap_len();
        out_ch.ready <= 1'b1;
      end
    end
  end

  // keep the input pins known before the first drive
  initial begin
    in_ch.valid = 1'b0;
    in_ch.kind = 3'd0;
    in_ch.reg_index = 3'd0;
    in_ch.data = 8'd0;
    in_ch.pattern_byte = 8'd0;
    out_ch.ready = 1'b0;
  end

  task automatic write_cfg(logic idx, logic [1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MIRRORING) mir_mode = val;
    else pat_ram_en = val[0];
  endtask

  task automatic drain();
    wait (pending_items.size() == 0 && !in_ch.valid && expected_results.size() == 0);
    repeat (4) @(posedge clk);
  endtask

  // set v through the address register
  task automatic push_addr(logic [13:0] a);
    pending_items.push_back(mk(KIND_READ, REG_STATUS, 8'd0, 8'd0));
    pending_items.push_back(mk(KIND_WRITE, REG_ADDR, {2'b00, a[13:8]}, 8'd0));
    pending_items.push_back(mk(KIND_WRITE, REG_ADDR, a[7:0], 8'd0));
  endtask

  function automatic logic [13:0] rand_addr();
    case ($urandom_range(0, 3))
      0: return 14'($urandom_range(0, 14'h1FFF));
      1: return 14'($urandom_range(14'h2000, 14'h2FFF));
      2: return 14'($urandom_range(14'h3000, 14'h3EFF));
      default: return 14'($urandom_range(14'h3F00, 14'h3FFF));
    endcase
  endfunction

  task automatic random_phase(int n);
    int p;
    logic [2:0] ri;
    repeat (n) begin
      p = $urandom_range(0, 99);
      if (p < 12) begin
        push_addr(rand_addr());
      end else if (p < 30) begin
        pending_items.push_back(mk(kind_t'($urandom_range(0, 1)), REG_DATA,
                                   8'($urandom), 8'($urandom)));
      end else if (p < 45) begin
        pending_items.push_back(mk(kind_t'($urandom_range(2, 5)), 3'($urandom),
                                   8'($urandom), 8'($urandom)));
      end else if (p < 52) begin
        pending_items.push_back(mk(kind_t'($urandom_range(6, 7)), 3'($urandom),
                                   8'($urandom), 8'($urandom)));
      end else if (p < 58) begin
        pending_items.push_back(mk(KIND_WRITE, REG_MASK, 8'($urandom_range(0, 1) ? 8'h18 :
                                   8'($urandom)), 8'($urandom)));
      end else begin
        ri = 3'($urandom);
        pending_items.push_back(mk(kind_t'($urandom_range(0, 1)), ri, 8'($urandom),
                                   8'($urandom)));
      end
    end
  endtask

  // stimulus
  initial begin
    mir_mode = 2'd0; pat_ram_en = 1'b0;
    ctrl_r = '0; mask_r = '0; latch_r = '0; rbuf_r = '0; oam_addr_r = '0;
    stat_r = '0; fx_r = '0; v_r = '0; t_r = '0;
    toggle_r = 1'b0; vblank_r = 1'b0; nmi_done_r = 1'b0;
    foreach (oam_mem[i]) oam_mem[i] = 8'd0;
    foreach (nt_mem[i]) nt_mem[i] = 8'd0;
    foreach (pal_mem[i]) pal_mem[i] = 8'd0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    write_cfg(CFG_PATTERN_RAM, 2'd1);
    write_cfg(CFG_MIRRORING, 2'd1);

    // directed: pattern write, palette mirror, buffered reads, nmi, rendering
    push_addr(14'h1FFF);
    pending_items.push_back(mk(KIND_WRITE, REG_DATA, 8'hFF, 8'h00));
    push_addr(14'h3F10);
    pending_items.push_back(mk(KIND_WRITE, REG_DATA, 8'hA5, 8'h00));
    pending_items.push_back(mk(KIND_READ, REG_DATA, 8'h00, 8'hFF));
    push_addr(14'h3F00);
    pending_items.push_back(mk(KIND_READ, REG_DATA, 8'h00, 8'h00));
    pending_items.push_back(mk(KIND_WRITE, REG_STATUS, 8'hFF, 8'h00));
    pending_items.push_back(mk(KIND_READ, REG_MASK, 8'h00, 8'h00));
    pending_items.push_back(mk(KIND_WRITE, REG_CTRL, 8'h84, 8'h00));
    pending_items.push_back(mk(KIND_VBLANK, 3'd0, 8'h00, 8'h00));
    pending_items.push_back(mk(KIND_VBLANK, 3'd0, 8'h00, 8'h00));
    pending_items.push_back(mk(KIND_READ, REG_STATUS, 8'h00, 8'h00));
    pending_items.push_back(mk(KIND_WRITE, REG_CTRL, 8'h00, 8'h00));
    pending_items.push_back(mk(KIND_WRITE, REG_CTRL, 8'h80, 8'h00));
    pending_items.push_back(mk(KIND_FRAME_CLR, 3'd0, 8'h00, 8'h00));
    pending_items.push_back(mk(KIND_WRITE, REG_MASK, 8'h18, 8'h00));
    pending_items.push_back(mk(KIND_WRITE, REG_SCROLL, 8'hFF, 8'h00));
    pending_items.push_back(mk(KIND_WRITE, REG_SCROLL, 8'hFF, 8'h00));
    pending_items.push_back(mk(KIND_INC_X, 3'd0, 8'h00, 8'h00));
    pending_items.push_back(mk(KIND_INC_Y, 3'd0, 8'h00, 8'h00));
    pending_items.push_back(mk(KIND_COPY_X, 3'd0, 8'h00, 8'h00));
    pending_items.push_back(mk(KIND_COPY_Y, 3'd0, 8'h00, 8'h00));
    drain();

    // random phases across mirroring settings, unused code and both pattern modes
    write_cfg(CFG_MIRRORING, 2'd0);
    write_cfg(CFG_PATTERN_RAM, 2'd0);
    random_phase(130);
    drain();
    write_cfg(CFG_MIRRORING, 2'd2);
    random_phase(130);
    drain();
    write_cfg(CFG_MIRRORING, 2'd3);
    write_cfg(CFG_PATTERN_RAM, 2'd1);
    random_phase(90);
    drain();
    write_cfg(CFG_MIRRORING, 2'd1);
    random_phase(100);
    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
`default_nettype wire

### sim.f
+incdir+sv
sv/vrp_pkg.sv
sv/vrp_if.sv
sv/vrp_queue.sv
sv/vrp_exec.sv
sv/video_register_and_vram_port.sv
test/video_register_and_vram_port_test.sv
